// ===== rtl/ole_pkg.sv =====
// Package for the ordered list engine: sizes, operation and status codes.
// Used by ole_cell and ordered_list_engine; depends on nothing.
package ole_pkg;

    localparam int Capacity = 64;
    localparam int IdxW     = $clog2(Capacity);
    localparam int CntW     = $clog2(Capacity + 1);
    localparam int ValW     = 32;

    typedef logic [3:0] func_t;
    localparam func_t FN_INS_HEAD  = 4'd0;
    localparam func_t FN_INS_TAIL  = 4'd1;
    localparam func_t FN_INS_POS   = 4'd2;
    localparam func_t FN_INS_AFTER = 4'd3;
    localparam func_t FN_INS_BEFOR = 4'd4;
    localparam func_t FN_DEL_HEAD  = 4'd5;
    localparam func_t FN_DEL_TAIL  = 4'd6;
    localparam func_t FN_EDIT      = 4'd7;
    localparam func_t FN_REVERSE   = 4'd8;
    localparam func_t FN_SORT      = 4'd9;
    localparam func_t FN_COUNT     = 4'd10;
    localparam func_t FN_READ_ALL  = 4'd11;

    typedef logic [1:0] status_t;
    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_IGNORED = 2'd1;
    localparam status_t ST_FULL    = 2'd2;
    localparam status_t ST_UNKNOWN = 2'd3;

    // Row-wide command applied by every cell in the same cycle.
    typedef enum logic [2:0] {
        CC_HOLD,
        CC_INSERT,   // cells above sel take left neighbour, cell sel takes value
        CC_REMOVE,   // cells at or above sel take right neighbour
        CC_WRITE,    // cell sel takes value
        CC_ROTATE,   // cells below len-1 take right neighbour, cell len-1 takes the head
        CC_SWAP_EVEN,// odd-even sort phase, pairs (0,1),(2,3)...
        CC_SWAP_ODD  // pairs (1,2),(3,4)...
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [IdxW-1:0]   sel;
        logic [CntW-1:0]   len;
        logic [ValW-1:0]   value;
    } cell_ctl_t;

endpackage

// ===== rtl/ole_cell.sv =====
// One list cell: holds one element and moves it to or from its neighbours.
// Depends on ole_pkg.
module ole_cell (
    input  logic                     aclk,
    input  ole_pkg::cell_ctl_t       ctl,
    input  logic [ole_pkg::IdxW-1:0] my_idx,
    input  logic [ole_pkg::ValW-1:0] left_val,
    input  logic [ole_pkg::ValW-1:0] right_val,
    input  logic [ole_pkg::ValW-1:0] head_val,
    output logic [ole_pkg::ValW-1:0] val
);
    import ole_pkg::*;

    logic [ValW-1:0] val_reg;
    logic [ValW-1:0] val_next;
    logic            lo_side;   // this cell is the lower of its sort pair
    logic            even_pair;
    logic [CntW-1:0] idx_w;
    logic [CntW-1:0] idx_up;

    assign val = val_reg;
    assign even_pair = (ctl.cmd == CC_SWAP_EVEN);
    assign lo_side = even_pair ? ~my_idx[0] : my_idx[0];
    assign idx_w  = CntW'(my_idx);
    assign idx_up = idx_w + CntW'(1);

    // Next value selected by the row command.
    always_comb begin
        val_next = val_reg;
        case (ctl.cmd)
            CC_INSERT: begin
                if (my_idx == ctl.sel) val_next = ctl.value;
                else if (my_idx > ctl.sel) val_next = left_val;
            end
            CC_REMOVE: begin
                if (my_idx >= ctl.sel) val_next = right_val;
            end
            CC_WRITE: begin
                if (my_idx == ctl.sel) val_next = ctl.value;
            end
            // Rotation of the first len cells; the head wraps to cell len-1.
            CC_ROTATE: begin
                if (idx_up < ctl.len) val_next = right_val;
                else if (idx_up == ctl.len) val_next = head_val;
            end
            CC_SWAP_EVEN, CC_SWAP_ODD: begin
                if (lo_side) begin
                    if (idx_up < ctl.len && $signed(val_reg) > $signed(right_val))
                        val_next = right_val;
                end else if (my_idx != '0 && idx_w < ctl.len) begin
                    if ($signed(left_val) > $signed(val_reg)) val_next = left_val;
                end
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

// ===== rtl/ordered_list_engine.sv =====
// Ordered list engine: a row of 64 element cells under a sequencing controller.
// Head/tail inserts, deletes and count go straight to the result; insert at position and
// edit pass through search; reverse and sort run their own states; insert after/before
// scans first (one compare per cycle). Read-all then gives one result per cycle while
// m_tready is high. One item at a time; the next is accepted after the last transfer.
// Reset (aresetn low, synchronous) empties the list; cell contents are undefined.
module ordered_list_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: func[3:0], value[35:4], position[42:36], ref_value[74:43], zero pad
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status[1:0], data[33:2], length[40:34], zero pad
    output logic [47:0] m_tdata,
    output logic        m_tlast
);
    import ole_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_SORT, S_READ, S_REV, S_OUT} state_t;

    state_t          state_reg;
    func_t           func_reg;
    logic [31:0]     value_reg;
    logic [31:0]     ref_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] step_reg;
    logic [IdxW-1:0] hit_reg;
    logic            found_reg;
    logic [1:0]      st_reg;
    logic [31:0]     data_reg;
    logic            last_reg;
    logic            ins_pending_reg;
    cell_ctl_t       ctl;
    logic [31:0]     cell_val [Capacity];
    logic            m_xfer;
    func_t           fn_in;
    logic [6:0]      pos_in;
    logic [6:0]      ins_t;
    logic [6:0]      edit_t;
    state_t          dec_state;
    logic [1:0]      dec_st;
    logic [CntW-1:0] dec_count;
    logic [CntW-1:0] dec_step;
    logic [IdxW-1:0] dec_hit;
    logic            dec_ins;
    logic            dec_found;
    logic            edit_now;

    // Row of cells; neighbour links wrap at the ends of the row.
    for (genvar g = 0; g < Capacity; g++) begin : g_cell
        ole_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .my_idx    (IdxW'(g)),
            .left_val  (cell_val[(g + Capacity - 1) % Capacity]),
            .right_val (cell_val[(g + 1) % Capacity]),
            .head_val  (cell_val[0]),
            .val       (cell_val[g])
        );
    end

    // Insert-at-position and edit targets.
    assign fn_in  = s_tdata[3:0];
    assign pos_in = s_tdata[42:36];
    assign ins_t  = (pos_in == 7'd0) ? 7'd1 : pos_in - 7'd1;
    assign edit_t = (pos_in == 7'd0) ? 7'd0 : pos_in - 7'd1;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT) || (state_reg == S_READ && step_reg != '0);
    assign m_tdata  = {7'd0, count_reg, data_reg, st_reg};
    assign m_tlast  = last_reg;
    assign m_xfer   = m_tvalid && m_tready;

    // Row command for this cycle.
    always_comb begin
        ctl.cmd   = CC_HOLD;
        ctl.sel   = hit_reg;
        ctl.len   = count_reg;
        ctl.value = value_reg;
        unique case (state_reg)
            S_SORT:  ctl.cmd = step_reg[0] ? CC_SWAP_ODD : CC_SWAP_EVEN;
            // Rotate the whole list once for each element handed out.
            S_READ: begin
                if (step_reg == '0 || (m_xfer && step_reg != count_reg))
                    ctl.cmd = CC_ROTATE;
            end
            // Reverse by rotating ever shorter prefixes.
            S_REV: begin
                ctl.cmd = CC_ROTATE;
                ctl.len = step_reg;
            end
            S_SEARCH: begin
                if (ins_pending_reg) ctl.cmd = CC_INSERT;
                else if (found_reg) ctl.cmd = CC_WRITE;
            end
            S_OUT: ctl.cmd = CC_HOLD;
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    ctl.value = s_tdata[35:4];
                    unique case (fn_in)
                        FN_INS_HEAD: if (count_reg < CntW'(Capacity)) begin
                            ctl.cmd = CC_INSERT; ctl.sel = '0;
                        end
                        FN_INS_TAIL: if (count_reg < CntW'(Capacity)) begin
                            ctl.cmd = CC_INSERT; ctl.sel = IdxW'(count_reg);
                        end
                        FN_DEL_HEAD: if (count_reg != '0) begin
                            ctl.cmd = CC_REMOVE; ctl.sel = '0;
                        end
                        default: ctl.cmd = CC_HOLD;
                    endcase
                end
            end
            default: ctl.cmd = CC_HOLD;
        endcase
    end

    // Decode of an accepted item: status, next state and list count.
    always_comb begin
        dec_state = S_OUT;
        dec_st    = ST_DONE;
        dec_count = count_reg;
        dec_hit   = hit_reg;
        dec_step  = '0;
        dec_ins   = 1'b0;
        dec_found = 1'b0;
        if (fn_in <= FN_INS_BEFOR && count_reg >= CntW'(Capacity)) begin
            dec_st = ST_FULL;
        end else begin
            unique case (fn_in) inside
                FN_INS_HEAD, FN_INS_TAIL: dec_count = count_reg + CntW'(1);
                FN_INS_POS: begin
                    if (pos_in == 7'd1) begin
                        dec_hit = '0; dec_ins = 1'b1; dec_state = S_SEARCH;
                    end else if (count_reg == '0 || ins_t > 7'(count_reg)) begin
                        dec_st = ST_IGNORED;
                    end else begin
                        dec_hit = IdxW'(ins_t); dec_ins = 1'b1; dec_state = S_SEARCH;
                    end
                end
                FN_INS_AFTER, FN_INS_BEFOR: begin
                    if (count_reg == '0) dec_st = ST_IGNORED;
                    else dec_state = S_SEARCH;
                end
                FN_DEL_HEAD, FN_DEL_TAIL: begin
                    if (count_reg == '0) dec_st = ST_IGNORED;
                    else dec_count = count_reg - CntW'(1);
                end
                FN_EDIT: begin
                    if (edit_t < 7'(count_reg)) begin
                        dec_hit = IdxW'(edit_t); dec_found = 1'b1; dec_state = S_SEARCH;
                    end else dec_st = ST_IGNORED;
                end
                FN_REVERSE: if (count_reg > CntW'(1)) begin
                    dec_state = S_REV; dec_step = count_reg;
                end
                FN_SORT: if (count_reg > CntW'(1)) dec_state = S_SORT;
                FN_READ_ALL: begin
                    if (count_reg == '0) dec_st = ST_IGNORED;
                    else dec_state = S_READ;
                end
                FN_COUNT: dec_st = ST_DONE;
                default: dec_st = ST_UNKNOWN;
            endcase
        end
    end

    // Controller: one clocked block for state and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            ins_pending_reg <= 1'b0;
            step_reg        <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    func_reg  <= fn_in;
                    value_reg <= s_tdata[35:4];
                    ref_reg   <= s_tdata[74:43];
                    st_reg    <= dec_st;
                    data_reg  <= '0;
                    last_reg  <= 1'b1;
                    step_reg  <= dec_step;
                    found_reg <= dec_found;
                    ins_pending_reg <= dec_ins;
                    hit_reg   <= dec_hit;
                    count_reg <= dec_count;
                    state_reg <= dec_state;
                end
                // Search by rotating-free scan index; insert or write when found.
                S_SEARCH: begin
                    if (ins_pending_reg) begin
                        ins_pending_reg <= 1'b0;
                        count_reg <= count_reg + CntW'(1);
                        state_reg <= S_OUT;
                    end else if (found_reg) begin
                        state_reg <= S_OUT;
                    end else if (step_reg >= count_reg) begin
                        st_reg <= ST_IGNORED;
                        state_reg <= S_OUT;
                    end else if (cell_val[IdxW'(step_reg)] == ref_reg) begin
                        hit_reg <= (func_reg == FN_INS_AFTER) ?
                                   IdxW'(step_reg + CntW'(1)) : IdxW'(step_reg);
                        ins_pending_reg <= 1'b1;
                    end else begin
                        step_reg <= step_reg + CntW'(1);
                    end
                end
                S_SORT: begin
                    step_reg <= step_reg + CntW'(1);
                    if (step_reg + CntW'(1) >= count_reg) state_reg <= S_OUT;
                end
                // Reverse: prefix length runs from count down to two.
                S_REV: begin
                    step_reg <= step_reg - CntW'(1);
                    if (step_reg == CntW'(2)) state_reg <= S_OUT;
                end
                // Read-out: rotate once per transfer; cell 0 holds the next element.
                S_READ: begin
                    if (step_reg == '0) begin
                        data_reg <= cell_val[0];
                        last_reg <= (count_reg == CntW'(1));
                        step_reg <= CntW'(1);
                    end else if (m_xfer) begin
                        if (step_reg == count_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            data_reg <= cell_val[0];
                            last_reg <= (step_reg + CntW'(1) == count_reg);
                            step_reg <= step_reg + CntW'(1);
                        end
                    end
                end
                S_OUT: if (m_xfer) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Edit write cycle, watched by the checks below.
    assign edit_now = (state_reg == S_SEARCH) && found_reg && !ins_pending_reg;

`ifndef SYNTH
    // The list never grows beyond capacity.
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(Capacity)) else $error("count above capacity");
    // Results only appear while an item is in progress.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("result while idle");
    // A full refusal leaves the count unchanged.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == ST_FULL) |-> count_reg == CntW'(Capacity))
        else $error("full status with room");
    // Edit path is only taken for an edit.
    a_edit: assert property (@(posedge aclk) disable iff (!aresetn)
        edit_now |-> func_reg == FN_EDIT) else $error("stray edit");
`endif

endmodule
